>>> rtl/sprite_rect_clip_uv_top_assert.svh
// ----------------------------------------------------------------------------
// sprite_rect_clip_uv_top_assert.svh
// Assertion macros shared by the sprite clip block.
// ----------------------------------------------------------------------------
`ifndef SPRITE_RECT_CLIP_UV_TOP_ASSERT_SVH
`define SPRITE_RECT_CLIP_UV_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SRCU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SRCU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SRCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/srcu_pkg.sv
// ----------------------------------------------------------------------------
// srcu_pkg
// Register indexes and shared types of the sprite clip block.
// ----------------------------------------------------------------------------
package srcu_pkg;

  localparam int REG_IDX_BITS = 2;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_CLIP_LEFT   = 2'd0;
  localparam reg_idx_t REG_CLIP_TOP    = 2'd1;
  localparam reg_idx_t REG_CLIP_WIDTH  = 2'd2;
  localparam reg_idx_t REG_CLIP_HEIGHT = 2'd3;

endpackage

>>> rtl/srcu_div_cell.sv
// ----------------------------------------------------------------------------
// srcu_div_cell
// One restoring divide step: resolve one quotient bit and pass on.
// ----------------------------------------------------------------------------
module srcu_div_cell #(
  parameter int NW   = 32,
  parameter int DW   = 15,
  parameter int QW   = 17,
  parameter int PW   = 8,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_rem,
  input  logic [QW-1:0] in_quo,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_rem,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_den,
  output logic [PW-1:0] out_pay
);

  logic [NW-1:0] den_sh;
  logic          fits;

  assign den_sh = NW'(in_den) << STEP;
  assign fits   = (in_rem >= den_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // subtract the shifted divisor where it fits, and set this quotient bit
  always_ff @(posedge clk) begin
    out_rem <= fits ? (in_rem - den_sh) : in_rem;
    out_quo <= fits ? (in_quo | (QW'(1) << STEP)) : in_quo;
    out_den <= in_den;
    out_pay <= in_pay;
  end

endmodule

>>> rtl/srcu_div_chain.sv
// ----------------------------------------------------------------------------
// srcu_div_chain
// Row of divide cells, one quotient bit per cell, MSB first.
// ----------------------------------------------------------------------------
module srcu_div_chain #(
  parameter int NW = 32,
  parameter int DW = 15,
  parameter int QW = 17,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          v_w   [QW+1];
  logic [NW-1:0] rem_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];
  logic [DW-1:0] den_w [QW+1];
  logic [PW-1:0] pay_w [QW+1];

  assign v_w[0]   = in_valid;
  assign rem_w[0] = in_num;
  assign quo_w[0] = '0;
  assign den_w[0] = in_den;
  assign pay_w[0] = in_pay;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    srcu_div_cell #(
      .NW(NW), .DW(DW), .QW(QW), .PW(PW), .STEP(QW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v_w[i]),
      .in_rem   (rem_w[i]),
      .in_quo   (quo_w[i]),
      .in_den   (den_w[i]),
      .in_pay   (pay_w[i]),
      .out_valid(v_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_den  (den_w[i+1]),
      .out_pay  (pay_w[i+1])
    );
  end

  assign out_valid = v_w[QW];
  assign out_quo   = quo_w[QW];
  assign out_pay   = pay_w[QW];

endmodule

>>> rtl/srcu_axis.sv
// ----------------------------------------------------------------------------
// srcu_axis
// Clip one axis: near-edge trim, then far-edge trim, with UV shrink.
// ----------------------------------------------------------------------------
module srcu_axis #(
  parameter int CW = 16,
  parameter int UW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] pos,
  input  logic [CW-2:0]        size,
  input  logic [UW-1:0]        uv_lo,
  input  logic [UW-1:0]        uv_hi,
  input  logic signed [CW-1:0] clip_lo,
  input  logic signed [CW:0]   clip_hi,
  output logic                 out_valid,
  output logic                 out_reject,
  output logic signed [CW-1:0] out_pos,
  output logic [CW-2:0]        out_size,
  output logic [UW-1:0]        out_uv_lo,
  output logic [UW-1:0]        out_uv_hi
);

  localparam int SW  = CW - 1;
  localparam int SPW = UW + 1;
  localparam int NW  = UW + SW;
  localparam int EW  = CW + 2;

  typedef struct packed {
    logic                  rej;
    logic                  trim;
    logic                  neg;
    logic [SW-1:0]         over;
    logic signed [CW-1:0]  pos;
    logic [SW-1:0]         size;
    logic [UW-1:0]         lo;
    logic [UW-1:0]         hi;
    logic signed [SPW-1:0] span;
    logic signed [CW-1:0]  clo;
    logic signed [CW:0]    chi;
  } pay_t;

  localparam int PW = $bits(pay_t);

  // ---- entry: reject test and near-edge overhang
  logic signed [EW-1:0]  pos_e, size_e, lo_e, hi_e, over1_e;
  logic signed [SPW-1:0] span0;
  pay_t                  s0_next, s0;
  logic                  s0_valid;

  always_comb begin
    pos_e   = EW'(pos);
    size_e  = signed'(EW'(size));
    lo_e    = EW'(clip_lo);
    hi_e    = EW'(clip_hi);
    over1_e = lo_e - pos_e;
    span0   = signed'(SPW'(uv_hi)) - signed'(SPW'(uv_lo));
    s0_next.rej  = ((pos_e + size_e) < lo_e) || (pos_e > hi_e);
    s0_next.trim = (over1_e > 0);
    s0_next.neg  = (span0 < 0);
    s0_next.over = over1_e[SW-1:0];
    s0_next.pos  = pos;
    s0_next.size = size;
    s0_next.lo   = uv_lo;
    s0_next.hi   = uv_hi;
    s0_next.span = span0;
    s0_next.clo  = clip_lo;
    s0_next.chi  = clip_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0 <= s0_next;
  end

  // ---- multiply |span| by overhang
  logic [SPW-1:0] mag0;
  logic [NW-1:0]  m1_num;
  pay_t           m1;
  logic           m1_valid;

  assign mag0 = s0.neg ? SPW'(-s0.span) : SPW'(s0.span);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_num <= s0.trim ? (NW'(mag0[UW-1:0]) * NW'(s0.over)) : '0;
    m1     <= s0;
  end

  // ---- first divide
  logic          c1_valid;
  logic [UW-1:0] q1;
  pay_t          c1;

  srcu_div_chain #(.NW(NW), .DW(SW), .QW(UW), .PW(PW)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m1_valid),
    .in_num   (m1_num),
    .in_den   (m1.size),
    .in_pay   (m1),
    .out_valid(c1_valid),
    .out_quo  (q1),
    .out_pay  (c1)
  );

  // ---- apply near trim, find far-edge overhang
  logic signed [SPW-1:0] d1;
  logic signed [EW-1:0]  over2_e;
  pay_t                  s2_next, s2;
  logic                  s2_valid;

  always_comb begin
    s2_next = c1;
    d1      = '0;
    if (c1.trim) begin
      d1           = c1.neg ? -signed'(SPW'(q1)) : signed'(SPW'(q1));
      s2_next.pos  = c1.clo;
      s2_next.size = c1.size - c1.over;
    end
    s2_next.lo   = UW'(signed'(SPW'(c1.lo)) + d1);
    s2_next.span = c1.span - d1;
    s2_next.neg  = (s2_next.span < 0);
    over2_e      = EW'(s2_next.pos) + signed'(EW'(s2_next.size)) - EW'(c1.chi);
    s2_next.trim = (over2_e > 0);
    s2_next.over = over2_e[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

  // ---- second multiply
  logic [SPW-1:0] mag2;
  logic [NW-1:0]  m3_num;
  pay_t           m3;
  logic           m3_valid;

  assign mag2 = s2.neg ? SPW'(-s2.span) : SPW'(s2.span);

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    m3_num <= s2.trim ? (NW'(mag2[UW-1:0]) * NW'(s2.over)) : '0;
    m3     <= s2;
  end

  // ---- second divide
  logic          c3_valid;
  logic [UW-1:0] q3;
  pay_t          c3;

  srcu_div_chain #(.NW(NW), .DW(SW), .QW(UW), .PW(PW)) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m3_valid),
    .in_num   (m3_num),
    .in_den   (m3.size),
    .in_pay   (m3),
    .out_valid(c3_valid),
    .out_quo  (q3),
    .out_pay  (c3)
  );

  // ---- apply far trim
  logic signed [SPW-1:0] d3;
  logic signed [CW:0]    far_size;

  always_comb begin
    d3        = '0;
    far_size  = c3.chi - (CW+1)'(c3.pos);
    out_size  = c3.size;
    if (c3.trim) begin
      d3       = c3.neg ? -signed'(SPW'(q3)) : signed'(SPW'(q3));
      out_size = far_size[SW-1:0];
    end
    out_uv_hi = UW'(signed'(SPW'(c3.hi)) - d3);
  end

  assign out_valid  = c3_valid;
  assign out_reject = c3.rej;
  assign out_pos    = c3.pos;
  assign out_uv_lo  = c3.lo;

endmodule

>>> rtl/sprite_rect_clip_uv_top.sv
// ----------------------------------------------------------------------------
// sprite_rect_clip_uv_top
// Throughput: one item per cycle; busy stays low. Each axis holds two rows of
// divide cells, one quotient bit per cell.
// Reset: rst clears all valid flags and loads clip 0,0 at full size.
// The receiver cannot stall; done marks each result for one cycle.
// ----------------------------------------------------------------------------
`include "sprite_rect_clip_uv_top_assert.svh"

module sprite_rect_clip_uv_top #(
  parameter int COORD_BITS   = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  srcu_pkg::reg_idx_t           cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  // command
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-2:0]        size_w,
  input  logic [COORD_BITS-2:0]        size_h,
  input  logic [UV_FRAC_BITS:0]        tex_u_start,
  input  logic [UV_FRAC_BITS:0]        tex_v_start,
  input  logic [UV_FRAC_BITS:0]        tex_u_end,
  input  logic [UV_FRAC_BITS:0]        tex_v_end,
  // result
  output logic                         done,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-2:0]        out_w,
  output logic [COORD_BITS-2:0]        out_h,
  output logic [UV_FRAC_BITS:0]        out_u_start,
  output logic [UV_FRAC_BITS:0]        out_v_start,
  output logic [UV_FRAC_BITS:0]        out_u_end,
  output logic [UV_FRAC_BITS:0]        out_v_end
);

  import srcu_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = COORD_BITS - 1;
  localparam int UW = UV_FRAC_BITS + 1;

  // ---- clip registers
  logic signed [CW-1:0] clip_left, clip_top;
  logic [SW-1:0]        clip_width, clip_height;
  logic signed [CW:0]   clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= '1;
      clip_height <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_LEFT:   clip_left   <= cfg_data;
        REG_CLIP_TOP:    clip_top    <= cfg_data;
        REG_CLIP_WIDTH:  clip_width  <= cfg_data[SW-1:0];
        REG_CLIP_HEIGHT: clip_height <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // far clip edges, one bit wider so they never wrap
  assign clip_right  = (CW+1)'(clip_left) + signed'((CW+1)'(clip_width));
  assign clip_bottom = (CW+1)'(clip_top) + signed'((CW+1)'(clip_height));

  // every cycle may take a new item
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---- the two axes run side by side with equal latency
  logic                 x_valid, x_rej, y_valid, y_rej;
  logic signed [CW-1:0] x_pos, y_pos;
  logic [SW-1:0]        x_size, y_size;
  logic [UW-1:0]        x_lo, x_hi, y_lo, y_hi;

  srcu_axis #(.CW(CW), .UW(UW)) u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pos       (pos_x),
    .size      (size_w),
    .uv_lo     (tex_u_start),
    .uv_hi     (tex_u_end),
    .clip_lo   (clip_left),
    .clip_hi   (clip_right),
    .out_valid (x_valid),
    .out_reject(x_rej),
    .out_pos   (x_pos),
    .out_size  (x_size),
    .out_uv_lo (x_lo),
    .out_uv_hi (x_hi)
  );

  srcu_axis #(.CW(CW), .UW(UW)) u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pos       (pos_y),
    .size      (size_h),
    .uv_lo     (tex_v_start),
    .uv_hi     (tex_v_end),
    .clip_lo   (clip_top),
    .clip_hi   (clip_bottom),
    .out_valid (y_valid),
    .out_reject(y_rej),
    .out_pos   (y_pos),
    .out_size  (y_size),
    .out_uv_lo (y_lo),
    .out_uv_hi (y_hi)
  );

  // ---- output register: a sprite rejected on either axis yields zeros
  logic keep;
  assign keep = !(x_rej || y_rej);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    visible     <= keep;
    out_x       <= keep ? x_pos  : '0;
    out_y       <= keep ? y_pos  : '0;
    out_w       <= keep ? x_size : '0;
    out_h       <= keep ? y_size : '0;
    out_u_start <= keep ? x_lo   : '0;
    out_u_end   <= keep ? x_hi   : '0;
    out_v_start <= keep ? y_lo   : '0;
    out_v_end   <= keep ? y_hi   : '0;
  end

  // ---- checks
  `SRCU_ASSERT_ALWAYS(a_axis_lockstep, x_valid == y_valid, "axis pipelines out of step")
  `SRCU_ASSERT_NEXT(a_done_follows, x_valid, done, "result strobe missing")
  `SRCU_ASSERT_SAME(a_reject_zero, done && !visible, (out_w == '0) && (out_u_start == '0) && (out_v_end == '0), "rejected item not zeroed")
  `SRCU_ASSERT_SAME(a_left_inside, done && visible, out_x >= clip_left, "kept item left of clip")

endmodule
